// File: rtl/fpc_pkg.sv
`timescale 1ns / 1ps
package fpc_pkg;
  localparam int MaxSlotsDefault = 32;

  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_DROP    = 3'd2;
  localparam logic [2:0] OP_FIND    = 3'd3;
  localparam logic [2:0] OP_ALLOC   = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;

  localparam logic [1:0] LT_OBJECT = 2'd1;
  localparam logic [1:0] LT_SECOND = 2'd2;

  localparam logic [1:0] WC_THROUGH = 2'd1;
  localparam logic [1:0] WC_DELETE  = 2'd2;

  localparam logic [1:0] FA_NONE   = 2'd0;
  localparam logic [1:0] FA_FILL   = 2'd1;
  localparam logic [1:0] FA_DIRECT = 2'd2;
  localparam logic [1:0] FA_WRITE  = 2'd3;

  localparam logic [1:0] CA_NONE = 2'd0;
  localparam logic [1:0] CA_TO_CALLER = 2'd1;
  localparam logic [1:0] CA_TO_SLOT = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [14:0] page_index;
    logic [15:0] object_id;
    logic [4:0]  slot;
    logic [1:0]  lookup_type;
    logic [1:0]  write_command;
  } fpc_req_t;

  typedef struct packed {
    logic       hit;
    logic       slot_valid;
    logic [4:0] result_slot;
    logic [1:0] flash_action;
    logic [1:0] copy_action;
    logic       evicted;
    logic [4:0] evicted_slot;
  } fpc_rsp_t;
endpackage

// File: rtl/flash_page_cache_lru_controller.sv
`timescale 1ns / 1ps
// Slot tag and LRU controller. A transaction is taken when start is high and busy is low;
// its result is shown for one cycle with done, and the receiver cannot stall it. Each
// transaction walks the slots one per cycle through a single compare/subtract unit:
// a lookup scan, and on a read miss (other than LT_SECOND) or an allocate, an age scan
// when every slot is busy, then a free-slot scan. A read miss with every slot busy is the
// worst case; a hit is shorter. A slot_count write clears the valid map and needs the
// block idle.
module flash_page_cache_lru_controller #(
  parameter int MAX_SLOTS = fpc_pkg::MaxSlotsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fpc_pkg::fpc_req_t req,
  output logic              done,
  output fpc_pkg::fpc_rsp_t rsp,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_data
);
  import fpc_pkg::*;

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_AGE   = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]           state;
  logic [MAX_SLOTS-1:0] valid_map;
  logic [MAX_SLOTS-1:0] is_wc;
  logic [MAX_SLOTS-1:0] wthru;
  logic [14:0]          slot_page [MAX_SLOTS];
  logic [15:0]          slot_object [MAX_SLOTS];
  logic [31:0]          slot_stamp [MAX_SLOTS];
  logic [31:0]          access_clock;
  logic [CW-1:0]        count;
  fpc_req_t             cur;
  logic [CW-1:0]        idx;
  logic [31:0]          best;
  logic                 best_found;
  logic [IW-1:0]        best_idx;
  fpc_rsp_t             res;

  logic [IW-1:0] ix;
  logic          vld_i;
  logic [31:0]   age_i;
  logic          last;
  logic          all_busy;
  logic [MAX_SLOTS-1:0] cmask;

  assign ix    = idx[IW-1:0];
  assign vld_i = valid_map[ix];
  assign age_i = access_clock - slot_stamp[ix];
  assign last  = (idx + CW'(1)) >= count;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) cmask[i] = (CW'(i) < count);
  end
  assign all_busy = (valid_map & cmask) == cmask;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid_map    <= '0;
      is_wc        <= '0;
      wthru        <= '0;
      access_clock <= '0;
      count        <= CW'(MAX_SLOTS);
      done         <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_page[i]   <= '0;
        slot_object[i] <= '0;
        slot_stamp[i]  <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        valid_map <= '0;
        if (cfg_data == 6'd0) count <= CW'(1);
        else if ({26'd0, cfg_data} > MAX_SLOTS) count <= CW'(MAX_SLOTS);
        else count <= CW'(cfg_data);
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur        <= req;
            idx        <= '0;
            best       <= '0;
            best_found <= 1'b0;
            best_idx   <= '0;
            case (req.operation)
              OP_READ, OP_WRITE, OP_DROP, OP_FIND: begin
                res   <= '0;
                state <= S_LOOK;
              end
              OP_ALLOC: begin
                res   <= '0;
                state <= all_busy ? S_AGE : S_FREE;
              end
              OP_RELEASE: begin
                if ({{(32-5){1'b0}}, req.slot} < 32'(count)) begin
                  valid_map[req.slot[IW-1:0]]   <= 1'b0;
                  is_wc[req.slot[IW-1:0]]       <= 1'b0;
                  wthru[req.slot[IW-1:0]]       <= 1'b0;
                  slot_object[req.slot[IW-1:0]] <= '0;
                  res <= '{result_slot: req.slot, default: '0};
                end else begin
                  res <= '0;
                end
                state <= S_DONE;
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LOOK: begin
          if (cur.operation == OP_FIND ?
              (vld_i && is_wc[ix] && slot_object[ix] == cur.object_id) :
              (vld_i && !is_wc[ix] && slot_page[ix] == cur.page_index)) begin
            res.hit         <= 1'b1;
            res.result_slot <= 5'(ix);
            state           <= S_DONE;
            case (cur.operation)
              OP_FIND: res.slot_valid <= 1'b1;
              OP_READ: begin
                access_clock    <= access_clock + 32'd1;
                slot_stamp[ix]  <= access_clock + 32'd1;
                res.slot_valid  <= 1'b1;
                res.copy_action <= CA_TO_CALLER;
              end
              OP_WRITE: begin
                if (cur.write_command == WC_THROUGH) begin
                  slot_stamp[ix]   <= access_clock;
                  res.flash_action <= FA_WRITE;
                end else if (cur.write_command == WC_DELETE &&
                             cur.lookup_type != LT_OBJECT) begin
                  valid_map[ix]    <= 1'b0;
                  is_wc[ix]        <= 1'b0;
                  wthru[ix]        <= 1'b0;
                  res.flash_action <= FA_WRITE;
                end else begin
                  access_clock     <= access_clock + 32'd1;
                  slot_stamp[ix]   <= access_clock + 32'd1;
                  res.slot_valid   <= 1'b1;
                  res.copy_action  <= CA_TO_SLOT;
                  res.flash_action <= wthru[ix] ? FA_WRITE : FA_NONE;
                end
              end
              default: begin
                valid_map[ix] <= 1'b0;
                is_wc[ix]     <= 1'b0;
                wthru[ix]     <= 1'b0;
              end
            endcase
          end else if (last) begin
            idx   <= '0;
            state <= S_DONE;
            case (cur.operation)
              OP_READ: begin
                access_clock <= access_clock + 32'd1;
                if (cur.lookup_type == LT_SECOND) res.flash_action <= FA_DIRECT;
                else state <= all_busy ? S_AGE : S_FREE;
              end
              OP_WRITE: res.flash_action <= FA_WRITE;
              default: ;
            endcase
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_AGE: begin
          // strictly greater keeps the lowest slot on a tie
          if (age_i > best && !is_wc[ix]) begin
            best       <= age_i;
            best_found <= 1'b1;
            best_idx   <= ix;
          end
          if (last) begin
            idx   <= '0;
            state <= S_FREE;
            if (age_i > best && !is_wc[ix]) begin
              valid_map[ix]    <= 1'b0;
              is_wc[ix]        <= 1'b0;
              wthru[ix]        <= 1'b0;
              res.evicted      <= 1'b1;
              res.evicted_slot <= 5'(ix);
            end else if (best_found) begin
              valid_map[best_idx] <= 1'b0;
              is_wc[best_idx]     <= 1'b0;
              wthru[best_idx]     <= 1'b0;
              res.evicted         <= 1'b1;
              res.evicted_slot    <= 5'(best_idx);
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_FREE: begin
          if (!vld_i) begin
            valid_map[ix]   <= 1'b1;
            slot_stamp[ix]  <= access_clock;
            res.slot_valid  <= 1'b1;
            res.result_slot <= 5'(ix);
            state           <= S_DONE;
            if (cur.operation == OP_READ) begin
              is_wc[ix]        <= 1'b0;
              wthru[ix]        <= 1'b1;
              slot_page[ix]    <= cur.page_index;
              res.flash_action <= FA_FILL;
              res.copy_action  <= CA_TO_CALLER;
            end else begin
              is_wc[ix]       <= 1'b1;
              wthru[ix]       <= 1'b0;
              slot_object[ix] <= cur.object_id;
            end
          end else if (last) begin
            state <= S_DONE;
            if (cur.operation == OP_READ) res.flash_action <= FA_DIRECT;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp = res;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_AGE && last) |-> all_busy) else $error("eviction without full map");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK || state == S_AGE || state == S_FREE) |-> idx < count)
    else $error("scan index past count");
endmodule
